>>> rtl/fpm_pkg.sv
// Package with the constants shared by the binary32 multiplier.
package fpm_pkg;
    localparam int unsigned ExpBias     = 127;
    localparam int unsigned ExpMaxFin   = 254;
    localparam logic [7:0]  ExpAllOnes  = 8'hff;
    localparam logic [31:0] CanonNan    = 32'h7fc0_0000;
    localparam int unsigned TdataInW    = 64;
    localparam int unsigned TdataOutW   = 40;
endpackage

>>> rtl/fp32_multiply.sv
// Top level of the single-precision floating-point multiplier.
//
// The input stream carries one operand pair per transaction; the output stream
// carries the rounded product and its overflow and underflow flags. Each
// transaction passes through an input register and a result register with the
// combinational logic between them, including the 24x24 significand
// multiplier that bounds the clock. m_tvalid rises once the result register
// has been loaded from the input register; one transaction is accepted every
// cycle while the receiver takes results.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready then drops until space frees. Results appear in
// acceptance order. Subnormal operands count as zeros; NaN inputs give the
// canonical quiet NaN. Rounding is to nearest, ties to even.
// Reset clears both valid flags; no transaction is in flight afterward and
// s_tready is high as soon as reset is released.
// A result with the exponent above 254 after rounding gives an infinity with
// overflow set; below 1 it gives a signed zero with underflow set.
module fp32_multiply
    import fpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TdataInW-1:0]  s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TdataOutW-1:0] m_tdata    // product [31:0], overflow [32],
                                            // underflow [33], zero fill [39:34]
);
    logic        in_vld_reg, out_vld_reg;
    logic [31:0] a_reg, b_reg;
    logic [33:0] res_reg, res_next;
    logic        out_adv, in_adv;

    assign out_adv  = !out_vld_reg || m_tready;
    assign in_adv   = !in_vld_reg || out_adv;
    assign s_tready = in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_adv) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_adv) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            a_reg <= s_tdata[31:0];
            b_reg <= s_tdata[63:32];
        end
        if (out_adv && in_vld_reg) begin
            res_reg <= res_next;
        end
    end

    logic        sgn, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [47:0] prod;
    logic [23:0] sig, sig_r;
    logic [23:0] rem, half;
    logic        rnd;
    logic [9:0]  exp_s;   // signed, biased
    logic [24:0] sig_sum;

    always_comb begin
        sgn    = a_reg[31] ^ b_reg[31];
        nan_a  = (a_reg[30:23] == ExpAllOnes) && (a_reg[22:0] != '0);
        nan_b  = (b_reg[30:23] == ExpAllOnes) && (b_reg[22:0] != '0);
        inf_a  = (a_reg[30:23] == ExpAllOnes) && (a_reg[22:0] == '0);
        inf_b  = (b_reg[30:23] == ExpAllOnes) && (b_reg[22:0] == '0);
        zero_a = (a_reg[30:23] == '0);
        zero_b = (b_reg[30:23] == '0);
        prod   = {1'b1, a_reg[22:0]} * {1'b1, b_reg[22:0]};
        exp_s  = {2'b00, a_reg[30:23]} + {2'b00, b_reg[30:23]} - 10'(ExpBias);
        if (prod[47]) begin
            sig   = prod[47:24];
            rem   = prod[23:0];
            half  = 24'h80_0000;
            exp_s = exp_s + 10'd1;
        end else begin
            sig   = prod[46:23];
            rem   = {1'b0, prod[22:0]};
            half  = 24'h40_0000;
        end
        rnd     = (rem > half) || ((rem == half) && sig[0]);
        sig_sum = {1'b0, sig} + {24'd0, rnd};
        sig_r   = sig_sum[23:0];
        if (sig_sum[24]) begin
            sig_r = sig_sum[24:1];
            exp_s = exp_s + 10'd1;
        end
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
            res_next = {2'b00, CanonNan};
        end else if (inf_a || inf_b) begin
            res_next = {2'b00, sgn, ExpAllOnes, 23'd0};
        end else if (zero_a || zero_b) begin
            res_next = {2'b00, sgn, 31'd0};
        end else if ($signed(exp_s) > $signed(10'(ExpMaxFin))) begin
            res_next = {2'b01, sgn, ExpAllOnes, 23'd0};
        end else if ($signed(exp_s) < $signed(10'd1)) begin
            res_next = {2'b10, sgn, 31'd0};
        end else begin
            res_next = {2'b00, sgn, exp_s[7:0], sig_r[22:0]};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, res_reg};

`ifndef SYNTH
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("overflow and underflow both set");
    a_ovf_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[30:0] == {ExpAllOnes, 23'd0}))
        else $error("overflow without infinity");
    a_unf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[30:0] == '0))
        else $error("underflow without zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_adv) |=> (in_vld_reg && $stable(a_reg) && $stable(b_reg)))
        else $error("input register lost a transaction");
`endif
endmodule
